// File: src/printf_conversion_spec_parser_assert.svh
// Assertion macros shared by the checker of the conversion spec parser.
`ifndef PRINTF_CONVERSION_SPEC_PARSER_ASSERT_SVH
`define PRINTF_CONVERSION_SPEC_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PCSP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PCSP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/pcsp_pkg.sv
`timescale 1ns / 1ps
package pcsp_pkg;

	// Accumulator range: width and precision saturate at 2^NUM_BITS-1.
	localparam int NUM_BITS = 16;
	localparam int ACC_W    = NUM_BITS;
	localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
	localparam int PROD_W   = ACC_W + 5;

	// Field widths of the result transaction.
	localparam int WIDTH_W = 16;
	localparam int PREC_W  = 17;

	// Conversion classes.
	localparam logic [3:0] CLASS_STRING   = 4'd0;
	localparam logic [3:0] CLASS_POINTER  = 4'd1;
	localparam logic [3:0] CLASS_SIGNED   = 4'd2;
	localparam logic [3:0] CLASS_OCTAL    = 4'd3;
	localparam logic [3:0] CLASS_UNSIGNED = 4'd4;
	localparam logic [3:0] CLASS_HEX      = 4'd5;
	localparam logic [3:0] CLASS_CHAR     = 4'd6;
	localparam logic [3:0] CLASS_WCHAR    = 4'd7;
	localparam logic [3:0] CLASS_LITERAL  = 4'd8;

	// Flag bits.
	localparam logic [4:0] FLAG_MINUS = 5'h01;
	localparam logic [4:0] FLAG_PLUS  = 5'h02;
	localparam logic [4:0] FLAG_BLANK = 5'h04;
	localparam logic [4:0] FLAG_HASH  = 5'h08;
	localparam logic [4:0] FLAG_ZFILL = 5'h10;

	// Length modifier bits.
	localparam logic [5:0] LEN_HH = 6'h01;
	localparam logic [5:0] LEN_H  = 6'h02;
	localparam logic [5:0] LEN_LL = 6'h04;
	localparam logic [5:0] LEN_L  = 6'h08;
	localparam logic [5:0] LEN_J  = 6'h10;
	localparam logic [5:0] LEN_Z  = 6'h20;

	// Byte kinds handed from the classifier to the executor.
	typedef enum logic [3:0] {
		BK_CONV,
		BK_DIGIT,
		BK_FLAG,
		BK_DOT,
		BK_LET_H,
		BK_LET_L,
		BK_LEN_J,
		BK_LEN_Z,
		BK_END
	} byte_kind_t;

	typedef struct packed {
		logic [7:0] ch;
		byte_kind_t kind;
		logic [3:0] cls;
		logic       force_long;
		logic [3:0] digit;
		logic [4:0] flag;
	} tok_t;

	typedef logic [7:0]               term_char_t;
	typedef logic [3:0]               conv_class_t;
	typedef logic [4:0]               flag_bits_t;
	typedef logic [WIDTH_W-1:0]       field_width_t;
	typedef logic signed [PREC_W-1:0] field_precision_t;
	typedef logic [5:0]               length_bits_t;

	// Classify one format byte.
	function automatic tok_t decode_byte(input logic [7:0] c);
		tok_t t;
		t.ch         = c;
		t.kind       = BK_END;
		t.cls        = CLASS_LITERAL;
		t.force_long = 1'b0;
		t.digit      = c[3:0];
		t.flag       = '0;
		unique case (c) inside
			"s": begin t.kind = BK_CONV; t.cls = CLASS_STRING; end
			"S": begin t.kind = BK_CONV; t.cls = CLASS_STRING; t.force_long = 1'b1; end
			"p": begin t.kind = BK_CONV; t.cls = CLASS_POINTER; end
			"d", "i": begin t.kind = BK_CONV; t.cls = CLASS_SIGNED; end
			"D": begin t.kind = BK_CONV; t.cls = CLASS_SIGNED; t.force_long = 1'b1; end
			"o": begin t.kind = BK_CONV; t.cls = CLASS_OCTAL; end
			"O": begin t.kind = BK_CONV; t.cls = CLASS_OCTAL; t.force_long = 1'b1; end
			"u": begin t.kind = BK_CONV; t.cls = CLASS_UNSIGNED; end
			"U": begin t.kind = BK_CONV; t.cls = CLASS_UNSIGNED; t.force_long = 1'b1; end
			"x", "X": begin t.kind = BK_CONV; t.cls = CLASS_HEX; end
			"c": begin t.kind = BK_CONV; t.cls = CLASS_CHAR; end
			"C": begin t.kind = BK_CONV; t.cls = CLASS_WCHAR; t.force_long = 1'b1; end
			["0":"9"]: t.kind = BK_DIGIT;
			"-": begin t.kind = BK_FLAG; t.flag = FLAG_MINUS; end
			"+": begin t.kind = BK_FLAG; t.flag = FLAG_PLUS; end
			" ": begin t.kind = BK_FLAG; t.flag = FLAG_BLANK; end
			"#": begin t.kind = BK_FLAG; t.flag = FLAG_HASH; end
			".": t.kind = BK_DOT;
			"h": t.kind = BK_LET_H;
			"l": t.kind = BK_LET_L;
			"j": t.kind = BK_LEN_J;
			"z": t.kind = BK_LEN_Z;
			default: t.kind = BK_END;
		endcase
		return t;
	endfunction

endpackage

// File: src/pcsp_if.sv
`timescale 1ns / 1ps
interface pcsp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink (input valid, input ch, output ready);
endinterface

interface pcsp_out_if import pcsp_pkg::*;;
	logic             valid;
	logic             ready;
	term_char_t       term_char;
	conv_class_t      conv_class;
	flag_bits_t       flag_bits;
	field_width_t     field_width;
	field_precision_t field_precision;
	length_bits_t     length_bits;
	logic             fill_zero;

	modport source (
		output valid, output term_char, output conv_class, output flag_bits,
		output field_width, output field_precision, output length_bits,
		output fill_zero, input ready
	);
	modport sink (
		input valid, input term_char, input conv_class, input flag_bits,
		input field_width, input field_precision, input length_bits,
		input fill_zero, output ready
	);
endinterface

// File: src/pcsp_front.sv
`timescale 1ns / 1ps
module pcsp_front import pcsp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	pcsp_in_if.sink byte_in,
	output tok_t    tok,
	output logic    tok_valid,
	input  logic    tok_pop
);

	localparam int QDEPTH = 2;
	localparam int PTR_W  = $clog2(QDEPTH);
	localparam int CNT_W  = $clog2(QDEPTH + 1);

	tok_t             q_tok_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	// Accept a byte whenever the queue has room.
	assign byte_in.ready = (cnt_q != CNT_W'(QDEPTH));
	assign push          = byte_in.valid && byte_in.ready;
	assign pop           = tok_pop && tok_valid;
	assign tok_valid     = (cnt_q != '0);
	assign tok           = q_tok_q[rd_ptr_q];

	// Store the classified byte.
	always_ff @(posedge clk) begin
		if (push) begin
			q_tok_q[wr_ptr_q] <= decode_byte(byte_in.ch);
		end
	end

	// Advance pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: src/pcsp_back.sv
`timescale 1ns / 1ps
module pcsp_back import pcsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  tok_t       tok,
	input  logic       tok_valid,
	output logic       tok_pop,
	pcsp_out_if.source spec_out
);

	typedef enum logic [1:0] {
		RUN_NONE,
		RUN_WIDTH,
		RUN_PREC
	} run_t;

	typedef enum logic [1:0] {
		PEND_NONE,
		PEND_H,
		PEND_L
	} pend_t;

	logic [4:0]       flags_q, flags_n;
	logic [ACC_W-1:0] width_q, width_n;
	logic [ACC_W-1:0] prec_q, prec_n;
	logic             prec_seen_q, prec_seen_n;
	logic [5:0]       len_q, len_n;
	run_t             run_q, run_n;
	pend_t            pend_q, pend_n;

	logic             out_valid_q;
	term_char_t       term_char_q;
	conv_class_t      conv_class_q;
	flag_bits_t       flag_bits_q;
	field_width_t     field_width_q;
	field_precision_t field_precision_q;
	length_bits_t     length_bits_q;
	logic             fill_zero_q;

	logic             take;
	logic             ends;
	logic             doubled;
	logic [3:0]       cls;
	logic [ACC_W-1:0] acc_sel;
	logic [PROD_W-1:0] acc_prod;
	logic [ACC_W-1:0] acc_sat;
	logic [31:0]      width_ext;
	logic [31:0]      prec_ext;

	// Take a token when the output slot is free or drains this cycle.
	assign take    = tok_valid && (!out_valid_q || spec_out.ready);
	assign tok_pop = take;

	// Shared digit unit: acc*10 + d, saturated.
	assign acc_sel  = (run_q == RUN_PREC) ? prec_q : width_q;
	assign acc_prod = {2'b00, acc_sel, 3'b000} + {4'b0000, acc_sel, 1'b0} + PROD_W'(tok.digit);
	assign acc_sat  = (acc_prod > PROD_W'(ACC_MAX)) ? ACC_MAX : acc_prod[ACC_W-1:0];

	// Next state for one byte.
	always_comb begin
		flags_n     = flags_q;
		width_n     = width_q;
		prec_n      = prec_q;
		prec_seen_n = prec_seen_q;
		len_n       = len_q;
		run_n       = run_q;
		pend_n      = pend_q;
		ends        = 1'b0;
		doubled     = 1'b0;
		cls         = CLASS_LITERAL;

		// Resolve a pending h or l.
		if (pend_q == PEND_H) begin
			pend_n = PEND_NONE;
			if (tok.kind == BK_LET_H) begin
				len_n   = len_n | LEN_HH;
				doubled = 1'b1;
			end else begin
				len_n = len_n | LEN_H;
			end
		end else if (pend_q == PEND_L) begin
			pend_n = PEND_NONE;
			if (tok.kind == BK_LET_L) begin
				len_n   = len_n | LEN_LL;
				doubled = 1'b1;
			end else begin
				len_n = len_n | LEN_L;
			end
		end

		if (!doubled) begin
			if (tok.kind == BK_CONV) begin
				ends = 1'b1;
				cls  = tok.cls;
			end else if (tok.kind == BK_DIGIT && run_q == RUN_WIDTH) begin
				width_n = acc_sat;
			end else if (tok.kind == BK_DIGIT && run_q == RUN_PREC) begin
				prec_n = acc_sat;
			end else begin
				run_n = RUN_NONE;
				unique case (tok.kind)
					BK_FLAG: flags_n = flags_q | tok.flag;
					BK_DIGIT: begin
						if (tok.digit == 4'd0) begin
							flags_n = flags_q | FLAG_ZFILL;
						end else begin
							width_n = ACC_W'(tok.digit);
							run_n   = RUN_WIDTH;
						end
					end
					BK_DOT: begin
						prec_n      = '0;
						prec_seen_n = 1'b1;
						run_n       = RUN_PREC;
					end
					BK_LET_H: pend_n = PEND_H;
					BK_LET_L: pend_n = PEND_L;
					BK_LEN_J: len_n = len_n | LEN_J;
					BK_LEN_Z: len_n = len_n | LEN_Z;
					default: begin
						ends = 1'b1;
						cls  = CLASS_LITERAL;
					end
				endcase
			end
		end
	end

	assign width_ext = 32'(width_q);
	assign prec_ext  = 32'(prec_q);

	// Hold parse state; drop back to reset after a terminator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q     <= '0;
			width_q     <= '0;
			prec_q      <= '0;
			prec_seen_q <= 1'b0;
			len_q       <= '0;
			run_q       <= RUN_NONE;
			pend_q      <= PEND_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				if (ends) begin
					flags_q     <= '0;
					width_q     <= '0;
					prec_q      <= '0;
					prec_seen_q <= 1'b0;
					len_q       <= '0;
					run_q       <= RUN_NONE;
					pend_q      <= PEND_NONE;
				end else begin
					flags_q     <= flags_n;
					width_q     <= width_n;
					prec_q      <= prec_n;
					prec_seen_q <= prec_seen_n;
					len_q       <= len_n;
					run_q       <= run_n;
					pend_q      <= pend_n;
				end
			end
			if (take && ends) begin
				out_valid_q <= 1'b1;
			end else if (spec_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load the result transaction.
	always_ff @(posedge clk) begin
		if (take && ends) begin
			term_char_q       <= tok.ch;
			conv_class_q      <= cls;
			flag_bits_q       <= flags_q;
			field_width_q     <= width_ext[WIDTH_W-1:0];
			field_precision_q <= prec_seen_q ? $signed(prec_ext[PREC_W-1:0]) : '1;
			length_bits_q     <= tok.force_long ? LEN_L : len_n;
			fill_zero_q       <= flags_q[4] && !flags_q[0];
		end
	end

	assign spec_out.valid           = out_valid_q;
	assign spec_out.term_char       = term_char_q;
	assign spec_out.conv_class      = conv_class_q;
	assign spec_out.flag_bits       = flag_bits_q;
	assign spec_out.field_width     = field_width_q;
	assign spec_out.field_precision = field_precision_q;
	assign spec_out.length_bits     = length_bits_q;
	assign spec_out.fill_zero       = fill_zero_q;

endmodule

// File: src/printf_conversion_spec_parser.sv
`timescale 1ns / 1ps
// Conversion specification parser for printf-style format strings.
// byte_in carries the bytes that follow a '%', one per transaction; a zero
// byte marks end of string. spec_out carries one transaction per finished
// specification: terminating byte, class, flags, width, precision, length
// bits and the zero-fill choice. Bytes that only extend the specification
// produce nothing on spec_out.
// Path: a terminating byte passes from the byte queue through the
// executor's output register before its result shows on spec_out.
// Throughput: one byte per cycle while spec_out is not held, set by the
// executor's state update and its shared digit multiply-add.
// Reset: the byte queue empties, parse state returns to no flags, width 0,
// precision absent, no length bits, and spec_out goes invalid.
// Stall: while spec_out is held, the result stays stable; the two-entry
// byte queue keeps taking bytes until full, then byte_in.ready drops.
module printf_conversion_spec_parser import pcsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	pcsp_in_if.sink    byte_in,
	pcsp_out_if.source spec_out
);

	tok_t tok;
	logic tok_valid;
	logic tok_pop;

	pcsp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_in   (byte_in),
		.tok       (tok),
		.tok_valid (tok_valid),
		.tok_pop   (tok_pop)
	);

	pcsp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok       (tok),
		.tok_valid (tok_valid),
		.tok_pop   (tok_pop),
		.spec_out  (spec_out)
	);

endmodule

// File: src/pcsp_checker.sv
`timescale 1ns / 1ps
`include "printf_conversion_spec_parser_assert.svh"
module pcsp_checker import pcsp_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input term_char_t       term_char,
	input conv_class_t      conv_class,
	input flag_bits_t       flag_bits,
	input length_bits_t     length_bits,
	input logic             fill_zero
);

	// Hold a stalled result transaction.
	`PCSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`PCSP_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(term_char) && $stable(flag_bits) && $stable(conv_class), "result changed while stalled")

	// Zero fill follows the zero and minus flags.
	`PCSP_ASSERT_NOW(a_fill_zero, out_valid, fill_zero == (flag_bits[4] && !flag_bits[0]), "fill choice disagrees with flags")

	// End of string is a literal; the S, D and C conversions force long.
	`PCSP_ASSERT_NOW(a_eos_class, out_valid && term_char == 8'h00, conv_class == CLASS_LITERAL, "end of string not a literal")
	`PCSP_ASSERT_NOW(a_force_long, out_valid && (term_char == "S" || term_char == "D" || term_char == "C"), length_bits == LEN_L, "long length not forced")

endmodule

bind printf_conversion_spec_parser pcsp_checker u_pcsp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (spec_out.valid),
	.out_ready   (spec_out.ready),
	.term_char   (spec_out.term_char),
	.conv_class  (spec_out.conv_class),
	.flag_bits   (spec_out.flag_bits),
	.length_bits (spec_out.length_bits),
	.fill_zero   (spec_out.fill_zero)
);
